[rtl/cslt_pkg.sv]
`default_nettype none

package cslt_pkg;

  localparam int POS_W = 32;
  localparam int LEN_W = 16;
  localparam int NKEY  = 13;

  localparam logic [LEN_W-1:0] LEN_MAX = {LEN_W{1'b1}};

  typedef enum logic [3:0] {
    MODE_IDLE,
    MODE_IDENT,
    MODE_INT,
    MODE_CHAR_OPEN,
    MODE_CHAR_GOT,
    MODE_STRING,
    MODE_HELD
  } mode_t;

  typedef struct packed {
    logic [5:0]  cls;
    logic [31:0] start;
    logic [15:0] len;
  } token_t;

  localparam logic [5:0] CLS_IDENT     = 6'd0;
  localparam logic [5:0] CLS_INT       = 6'd1;
  localparam logic [5:0] CLS_CHAR      = 6'd2;
  localparam logic [5:0] CLS_STRING    = 6'd3;
  localparam logic [5:0] CLS_KEY0      = 6'd4;
  localparam logic [5:0] CLS_PLUS      = 6'd17;
  localparam logic [5:0] CLS_MINUS     = 6'd18;
  localparam logic [5:0] CLS_STAR      = 6'd19;
  localparam logic [5:0] CLS_SLASH     = 6'd20;
  localparam logic [5:0] CLS_LT        = 6'd21;
  localparam logic [5:0] CLS_LE        = 6'd22;
  localparam logic [5:0] CLS_GT        = 6'd23;
  localparam logic [5:0] CLS_GE        = 6'd24;
  localparam logic [5:0] CLS_EQ        = 6'd25;
  localparam logic [5:0] CLS_NE        = 6'd26;
  localparam logic [5:0] CLS_ASSIGN    = 6'd27;
  localparam logic [5:0] CLS_SEMI      = 6'd28;
  localparam logic [5:0] CLS_COMMA     = 6'd29;
  localparam logic [5:0] CLS_LPAREN    = 6'd30;
  localparam logic [5:0] CLS_RPAREN    = 6'd31;
  localparam logic [5:0] CLS_LBRACKET  = 6'd32;
  localparam logic [5:0] CLS_RBRACKET  = 6'd33;
  localparam logic [5:0] CLS_LBRACE    = 6'd34;
  localparam logic [5:0] CLS_RBRACE    = 6'd35;
  localparam logic [5:0] CLS_ERROR     = 6'd36;

  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_BANG   = 8'h21;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_DQUOTE = 8'h22;

  localparam logic [7:0] KW_TEXT [NKEY][8] = '{
    '{"c", "o", "n", "s", "t", 8'h00, 8'h00, 8'h00},
    '{"i", "n", "t", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"c", "h", "a", "r", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"m", "a", "i", "n", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"v", "o", "i", "d", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"i", "f", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"e", "l", "s", "e", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"d", "o", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"w", "h", "i", "l", "e", 8'h00, 8'h00, 8'h00},
    '{"f", "o", "r", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"s", "c", "a", "n", "f", 8'h00, 8'h00, 8'h00},
    '{"p", "r", "i", "n", "t", "f", 8'h00, 8'h00},
    '{"r", "e", "t", "u", "r", "n", 8'h00, 8'h00}
  };

  localparam logic [2:0] KW_LEN [NKEY] = '{
    3'd5, 3'd3, 3'd4, 3'd4, 3'd4, 3'd2, 3'd4, 3'd2, 3'd5, 3'd3, 3'd5, 3'd6, 3'd6
  };

  function automatic logic is_space(logic [7:0] c);
    return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_alpha(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
  endfunction

  function automatic logic is_single(logic [7:0] c);
    return c == "+" || c == "-" || c == "*" || c == "/" || c == ";" || c == "," ||
           c == "(" || c == ")" || c == "[" || c == "]" || c == "{" || c == "}";
  endfunction

  function automatic logic [5:0] single_cls(logic [7:0] c);
    logic [5:0] r;
    r = CLS_RBRACE;
    unique case (c)
      "+":     r = CLS_PLUS;
      "-":     r = CLS_MINUS;
      "*":     r = CLS_STAR;
      "/":     r = CLS_SLASH;
      ";":     r = CLS_SEMI;
      ",":     r = CLS_COMMA;
      "(":     r = CLS_LPAREN;
      ")":     r = CLS_RPAREN;
      "[":     r = CLS_LBRACKET;
      "]":     r = CLS_RBRACKET;
      "{":     r = CLS_LBRACE;
      default: r = CLS_RBRACE;
    endcase
    return r;
  endfunction

  function automatic logic is_hold_op(logic [7:0] c);
    return c == CH_LT || c == CH_GT || c == CH_EQ || c == CH_BANG;
  endfunction

  function automatic logic [5:0] held_single_cls(logic [7:0] h);
    return (h == CH_LT) ? CLS_LT : (h == CH_GT) ? CLS_GT : CLS_ASSIGN;
  endfunction

  function automatic logic [5:0] held_pair_cls(logic [7:0] h);
    return (h == CH_LT) ? CLS_LE : (h == CH_GT) ? CLS_GE : (h == CH_EQ) ? CLS_EQ : CLS_NE;
  endfunction

  function automatic logic [5:0] word_cls(logic is_int, logic [NKEY-1:0] cands,
                                          logic [LEN_W-1:0] count);
    logic [5:0] r;
    r = CLS_IDENT;
    if (is_int) begin
      r = CLS_INT;
    end else begin
      for (int k = 0; k < NKEY; k++) begin
        if (cands[k] && count == LEN_W'(KW_LEN[k])) begin
          r = 6'(CLS_KEY0 + k);
        end
      end
    end
    return r;
  endfunction

  function automatic token_t make_token(logic [5:0] cls, logic [POS_W-1:0] start,
                                        logic [LEN_W-1:0] len);
    token_t t;
    t.cls   = cls;
    t.start = 32'(start);
    t.len   = 16'(len);
    return t;
  endfunction

endpackage

`default_nettype wire

[rtl/c_subset_lexical_tokenizer_core.sv]
// Streaming lexer for a small C subset. Source bytes enter on the char channel, one per
// cycle unless stalled, and token records (class, start position, length) leave on the
// token channel. A byte is registered on entry, then the lexer state and its tokens are
// formed from it into a single output register with one spill slot. Sustained
// rate is one byte per cycle while the token channel does not stall; a byte that yields
// two tokens holds the input while the spill slot drains through the output register.
// After an error token the block consumes and drops all bytes until reset.
`default_nettype none

module c_subset_lexical_tokenizer_core
  import cslt_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        char_valid,
  output logic             char_stall,
  input  wire logic [7:0]  ch,
  input  wire logic        end_of_text,
  output logic             token_valid,
  input  wire logic        token_stall,
  output logic [5:0]       token_class,
  output logic [31:0]      token_start,
  output logic [15:0]      token_length,
  output logic             last_result
);

  logic             in_full;
  logic [7:0]       ch_q;
  logic             eot_q;

  mode_t            mode;
  logic [POS_W-1:0] char_position;
  logic [POS_W-1:0] token_begin;
  logic [LEN_W-1:0] token_count;
  logic [NKEY-1:0]  cands;
  logic [7:0]       held;
  logic             halted;

  mode_t            mode_next;
  logic [POS_W-1:0] char_position_next;
  logic [POS_W-1:0] token_begin_next;
  logic [LEN_W-1:0] token_count_next;
  logic [NKEY-1:0]  cands_next;
  logic [7:0]       held_next;
  logic             halted_next;

  mode_t            mode1, mode2;
  logic [POS_W-1:0] begin2;
  logic [LEN_W-1:0] count2;
  logic [NKEY-1:0]  cands2;
  logic [7:0]       held2;
  logic             halt1, halt2, consumed;

  logic             out_full;
  token_t           out_tok;
  logic             out_last;
  logic             sec_full;
  token_t           sec_tok;

  logic             process;
  logic             room;
  logic             token_accept;

  logic             c_sp, c_al, c_dg;
  logic [LEN_W-1:0] count_bump;
  logic [NKEY-1:0]  kw_keep;
  logic [NKEY-1:0]  kw_first;

  logic             e1v, e2v, e3v;
  token_t           e1, e2, e3;
  token_t           r0, r1;
  logic [1:0]       nres;

  assign token_accept = out_full && !token_stall;
  assign room         = !out_full || (token_accept && !sec_full);
  assign process      = in_full && room;
  assign char_stall   = in_full && !process;

  assign c_sp = is_space(ch_q);
  assign c_al = is_alpha(ch_q);
  assign c_dg = is_digit(ch_q);
  assign count_bump = (token_count == LEN_MAX) ? token_count : token_count + LEN_W'(1);

  always_comb begin
    for (int k = 0; k < NKEY; k++) begin
      kw_keep[k]  = (token_count < LEN_W'(KW_LEN[k])) && (KW_TEXT[k][token_count[2:0]] == ch_q);
      kw_first[k] = (KW_TEXT[k][0] == ch_q);
    end
  end

  // next state: current byte closes the pending token, then may start one, then flush
  always_comb begin
    mode1    = mode;
    halt1    = halted;
    consumed = 1'b1;
    mode2    = mode;
    begin2   = token_begin;
    count2   = token_count;
    cands2   = cands;
    held2    = held;
    unique case (mode)
      MODE_IDENT: begin
        if (c_al || c_dg) begin
          cands2 = cands & kw_keep;
          count2 = count_bump;
        end else begin
          mode1    = MODE_IDLE;
          consumed = 1'b0;
        end
      end
      MODE_INT: begin
        if (c_dg) begin
          count2 = count_bump;
        end else begin
          mode1    = MODE_IDLE;
          consumed = 1'b0;
        end
      end
      MODE_CHAR_OPEN: begin
        begin2 = char_position;
        mode1  = MODE_CHAR_GOT;
      end
      MODE_CHAR_GOT: begin
        mode1 = MODE_IDLE;
      end
      MODE_STRING: begin
        if (ch_q == CH_DQUOTE) begin
          mode1 = MODE_IDLE;
        end else begin
          count2 = count_bump;
        end
      end
      MODE_HELD: begin
        mode1 = MODE_IDLE;
        if (ch_q != CH_EQ) begin
          consumed = 1'b0;
          halt1    = (held == CH_BANG);
        end
      end
      default: begin
        mode1    = MODE_IDLE;
        consumed = 1'b0;
      end
    endcase

    mode2 = mode1;
    halt2 = halt1;
    if (!consumed && !halt1) begin
      priority if (c_sp) begin
        mode2 = mode1;
      end else if (c_al) begin
        mode2  = MODE_IDENT;
        begin2 = char_position;
        count2 = LEN_W'(1);
        cands2 = kw_first;
      end else if (c_dg) begin
        mode2  = MODE_INT;
        begin2 = char_position;
        count2 = LEN_W'(1);
      end else if (ch_q == CH_SQUOTE) begin
        mode2  = MODE_CHAR_OPEN;
        begin2 = char_position;
      end else if (ch_q == CH_DQUOTE) begin
        mode2  = MODE_STRING;
        begin2 = char_position + POS_W'(1);
        count2 = '0;
      end else if (is_single(ch_q)) begin
        mode2 = mode1;
      end else if (is_hold_op(ch_q)) begin
        mode2  = MODE_HELD;
        held2  = ch_q;
        begin2 = char_position;
      end else begin
        mode2 = MODE_IDLE;
        halt2 = 1'b1;
      end
    end

    token_begin_next = begin2;
    token_count_next = count2;
    cands_next       = cands2;
    held_next        = held2;
    if (eot_q && !halt2) begin
      mode_next          = MODE_IDLE;
      char_position_next = '0;
      halted_next        = (mode2 == MODE_HELD && held2 == CH_BANG) ||
                           mode2 == MODE_CHAR_OPEN || mode2 == MODE_CHAR_GOT ||
                           mode2 == MODE_STRING;
    end else begin
      mode_next          = halt2 ? MODE_IDLE : mode2;
      char_position_next = char_position + POS_W'(1);
      halted_next        = halt2;
    end

    if (halted) begin
      mode_next          = mode;
      char_position_next = char_position;
      token_begin_next   = token_begin;
      token_count_next   = token_count;
      cands_next         = cands;
      held_next          = held;
      halted_next        = halted;
    end
  end

  // tokens of this byte, in order
  always_comb begin
    e1v = 1'b0;
    e1  = make_token(CLS_ERROR, token_begin, '0);
    unique case (mode)
      MODE_IDENT, MODE_INT: begin
        e1v = !consumed;
        e1  = make_token(word_cls(mode == MODE_INT, cands, token_count), token_begin,
                         token_count);
      end
      MODE_CHAR_GOT: begin
        e1v = 1'b1;
        e1  = make_token(CLS_CHAR, token_begin, LEN_W'(1));
      end
      MODE_STRING: begin
        e1v = (ch_q == CH_DQUOTE);
        e1  = make_token(CLS_STRING, token_begin, token_count);
      end
      MODE_HELD: begin
        e1v = 1'b1;
        if (ch_q == CH_EQ) begin
          e1 = make_token(held_pair_cls(held), token_begin, LEN_W'(2));
        end else if (held == CH_BANG) begin
          e1 = make_token(CLS_ERROR, token_begin, '0);
        end else begin
          e1 = make_token(held_single_cls(held), token_begin, LEN_W'(1));
        end
      end
      default: begin
        e1v = 1'b0;
      end
    endcase

    e2v = 1'b0;
    e2  = make_token(CLS_ERROR, char_position, '0);
    if (!consumed && !halt1 && !c_sp && !c_al && !c_dg && ch_q != CH_SQUOTE &&
        ch_q != CH_DQUOTE && !is_hold_op(ch_q)) begin
      e2v = 1'b1;
      if (is_single(ch_q)) begin
        e2 = make_token(single_cls(ch_q), char_position, LEN_W'(1));
      end
    end

    e3v = eot_q && !halt2 && (mode2 != MODE_IDLE);
    e3  = make_token(CLS_ERROR, begin2, '0);
    if (mode2 == MODE_IDENT || mode2 == MODE_INT) begin
      e3 = make_token(word_cls(mode2 == MODE_INT, cands2, count2), begin2, count2);
    end else if (mode2 == MODE_HELD && held2 != CH_BANG) begin
      e3 = make_token(held_single_cls(held2), begin2, LEN_W'(1));
    end

    if (halted) begin
      e1v = 1'b0;
      e2v = 1'b0;
      e3v = 1'b0;
    end

    r0   = e1;
    r1   = e3;
    nres = 2'd0;
    priority if (e1v) begin
      r0   = e1;
      r1   = e2v ? e2 : e3;
      nres = (e2v || e3v) ? 2'd2 : 2'd1;
    end else if (e2v) begin
      r0   = e2;
      r1   = e3;
      nres = e3v ? 2'd2 : 2'd1;
    end else if (e3v) begin
      r0   = e3;
      nres = 2'd1;
    end else begin
      nres = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (char_valid && !char_stall) begin
      in_full <= 1'b1;
    end else if (process) begin
      in_full <= 1'b0;
    end
    if (char_valid && !char_stall) begin
      ch_q  <= ch;
      eot_q <= end_of_text;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= MODE_IDLE;
      char_position <= '0;
      token_begin   <= '0;
      token_count   <= '0;
      cands         <= '0;
      held          <= '0;
      halted        <= 1'b0;
    end else if (process) begin
      mode          <= mode_next;
      char_position <= char_position_next;
      token_begin   <= token_begin_next;
      token_count   <= token_count_next;
      cands         <= cands_next;
      held          <= held_next;
      halted        <= halted_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_full <= 1'b0;
      sec_full <= 1'b0;
    end else if (process) begin
      out_full <= (nres != 2'd0);
      sec_full <= (nres == 2'd2);
    end else if (token_accept) begin
      out_full <= sec_full;
      sec_full <= 1'b0;
    end
    if (process) begin
      out_tok  <= r0;
      out_last <= (nres == 2'd1);
      sec_tok  <= r1;
    end else if (token_accept && sec_full) begin
      out_tok  <= sec_tok;
      out_last <= 1'b1;
    end
  end

  assign token_valid  = out_full;
  assign token_class  = out_tok.cls;
  assign token_start  = out_tok.start;
  assign token_length = out_tok.len;
  assign last_result  = out_last;

  a_spill_behind_out: assert property (@(posedge clk) disable iff (rst)
    sec_full |-> out_full)
    else $error("spill slot full while output register empty");

  a_spill_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (sec_full && in_full) |-> char_stall)
    else $error("item processed while spill slot still full");

  a_halt_sticks: assert property (@(posedge clk) disable iff (rst)
    halted |=> halted)
    else $error("halt cleared without reset");

  a_eot_restarts: assert property (@(posedge clk) disable iff (rst)
    (process && eot_q && !halted) |=>
      (mode == MODE_IDLE && (halted || char_position == '0)))
    else $error("end of text did not return lexer to idle");

  a_pair_spills: assert property (@(posedge clk) disable iff (rst)
    (process && nres == 2'd2) |=> (sec_full && out_full && !out_last))
    else $error("second token of an item lost");

endmodule

`default_nettype wire
